// ===== rtl/terminal_escape_sequence_parser_assert.svh =====
// assertion macros shared by the parser modules
`ifndef TERMINAL_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define TERMINAL_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH

// condition must hold on every clock outside reset
`define TESP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TESP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TESP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tesp_pkg.sv =====
// types, byte codes and byte classification for the escape sequence parser
package tesp_pkg;

    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int ICOUNT_W   = 2;
    localparam int KIND_W     = 3;
    localparam int OUT_DATA_W = 56;

    localparam logic [7:0] BYTE_BEL      = 8'h07;
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_C0_MAX   = 8'h1F;
    localparam logic [7:0] BYTE_INT_MIN  = 8'h20;
    localparam logic [7:0] BYTE_INT_MAX  = 8'h2F;
    localparam logic [7:0] BYTE_PAR_MIN  = 8'h30;
    localparam logic [7:0] BYTE_PAR_MAX  = 8'h3F;
    localparam logic [7:0] BYTE_SEP      = 8'h3B;
    localparam logic [7:0] BYTE_FIN_MIN  = 8'h40;
    localparam logic [7:0] BYTE_FIN_MAX  = 8'h7E;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_ST       = 8'h9C;
    localparam logic [7:0] BYTE_CSI_OPEN = 8'h5B;
    localparam logic [7:0] BYTE_OSC_OPEN = 8'h5D;
    localparam logic [7:0] BYTE_DCS_OPEN = 8'h50;
    localparam logic [7:0] BYTE_SOS_OPEN = 8'h58;
    localparam logic [7:0] BYTE_PM_OPEN  = 8'h5E;
    localparam logic [7:0] BYTE_APC_OPEN = 8'h5F;

    typedef enum logic [2:0] {
        KIND_PRINT,
        KIND_CONTROL,
        KIND_ESC_FINAL,
        KIND_CSI_PARAM,
        KIND_OSC_BYTE,
        KIND_OSC_END,
        KIND_DCS_BYTE,
        KIND_DCS_END
    } t_kind;

    typedef enum logic [3:0] {
        ST_GROUND,
        ST_ESCAPE,
        ST_CSI_ENTRY,
        ST_CSI_PARAM,
        ST_CSI_INTER,
        ST_OSC,
        ST_SOS,
        ST_DCS_ENTRY,
        ST_DCS_PARAM,
        ST_DCS_INTER,
        ST_DCS_PASS,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_DRAIN_LAST
    } t_state;

    typedef enum logic [2:0] {
        SRC_BYTE,
        SRC_CSI_EMPTY,
        SRC_CSI_ACC,
        SRC_DRAIN_MEM,
        SRC_DRAIN_ACC
    } t_src;

    typedef struct packed {
        logic esc;
        logic c0;
        logic del;
        logic param;
        logic sep;
        logic inter;
        logic fin;
        logic str_end;
        logic csi_open;
        logic osc_open;
        logic dcs_open;
        logic sos_open;
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic out_free;
        logic used_zero;
        logic used_one;
        logic drain_next_last;
    } t_sts;

    typedef struct packed {
        logic  in_ready;
        logic  emit;
        t_kind kind;
        t_src  src;
        logic  csi_start;
        logic  param_digit;
        logic  param_sep;
        logic  inter_collect;
        logic  drain_start;
        logic  drain_step;
    } t_cmd;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c.esc      = (b == BYTE_ESC);
        c.c0       = (b <= BYTE_C0_MAX);
        c.del      = (b == BYTE_DEL);
        c.param    = (b >= BYTE_PAR_MIN) && (b <= BYTE_PAR_MAX);
        c.sep      = (b == BYTE_SEP);
        c.inter    = (b >= BYTE_INT_MIN) && (b <= BYTE_INT_MAX);
        c.fin      = (b >= BYTE_FIN_MIN) && (b <= BYTE_FIN_MAX);
        c.str_end  = (b == BYTE_BEL) || (b == BYTE_ST);
        c.csi_open = (b == BYTE_CSI_OPEN);
        c.osc_open = (b == BYTE_OSC_OPEN);
        c.dcs_open = (b == BYTE_DCS_OPEN);
        c.sos_open = (b == BYTE_SOS_OPEN) || (b == BYTE_PM_OPEN) || (b == BYTE_APC_OPEN);
        return c;
    endfunction

endpackage

// ===== rtl/tesp_ctrl.sv =====
// parser mode and drain sequencer for the escape sequence parser
`include "terminal_escape_sequence_parser_assert.svh"

module tesp_ctrl
    import tesp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    t_state w_pass_state;
    logic   w_take;

    assign w_take = i_in_valid && i_sts.out_free;

    // where a dcs string goes on a byte that is passed through
    always_comb begin
        if (i_sts.cls.str_end) begin
            w_pass_state = ST_GROUND;
        end else if (i_sts.cls.esc) begin
            w_pass_state = ST_ESCAPE;
        end else begin
            w_pass_state = ST_DCS_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_GROUND;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_GROUND: begin
                if (w_take && i_sts.cls.esc) begin
                    n_state = ST_ESCAPE;
                end
            end
            ST_ESCAPE: begin
                if (w_take) begin
                    if (i_sts.cls.csi_open) begin
                        n_state = ST_CSI_ENTRY;
                    end else if (i_sts.cls.osc_open) begin
                        n_state = ST_OSC;
                    end else if (i_sts.cls.dcs_open) begin
                        n_state = ST_DCS_ENTRY;
                    end else if (i_sts.cls.sos_open) begin
                        n_state = ST_SOS;
                    end else begin
                        n_state = ST_GROUND;
                    end
                end
            end
            ST_CSI_ENTRY, ST_CSI_PARAM, ST_CSI_INTER: begin
                if (w_take) begin
                    if (r_state != ST_CSI_INTER && i_sts.cls.param) begin
                        n_state = ST_CSI_PARAM;
                    end else if (i_sts.cls.inter) begin
                        n_state = ST_CSI_INTER;
                    end else if (i_sts.cls.fin) begin
                        if (i_sts.used_zero || i_sts.used_one) begin
                            n_state = ST_GROUND;
                        end else begin
                            n_state = ST_DRAIN_RD;
                        end
                    end else if (i_sts.cls.esc) begin
                        n_state = ST_ESCAPE;
                    end
                end
            end
            ST_OSC: begin
                if (w_take) begin
                    if (i_sts.cls.str_end) begin
                        n_state = ST_GROUND;
                    end else if (i_sts.cls.esc) begin
                        n_state = ST_ESCAPE;
                    end
                end
            end
            ST_SOS: begin
                if (w_take && i_sts.cls.str_end) begin
                    n_state = ST_GROUND;
                end
            end
            ST_DCS_ENTRY, ST_DCS_PARAM: begin
                if (w_take) begin
                    if (i_sts.cls.param) begin
                        n_state = ST_DCS_PARAM;
                    end else if (i_sts.cls.inter) begin
                        n_state = ST_DCS_INTER;
                    end else begin
                        n_state = w_pass_state;
                    end
                end
            end
            ST_DCS_INTER: begin
                if (w_take && !i_sts.cls.inter) begin
                    n_state = w_pass_state;
                end
            end
            ST_DCS_PASS: begin
                if (w_take) begin
                    n_state = w_pass_state;
                end
            end
            ST_DRAIN_RD: begin
                n_state = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.drain_next_last ? ST_DRAIN_LAST : ST_DRAIN_RD;
                end
            end
            ST_DRAIN_LAST: begin
                if (i_sts.out_free) begin
                    n_state = ST_GROUND;
                end
            end
            default: begin
                n_state = ST_GROUND;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = KIND_PRINT;
        o_cmd.src      = SRC_BYTE;
        o_cmd.in_ready = i_sts.out_free;
        case (r_state)
            ST_GROUND: begin
                if (w_take && !i_sts.cls.esc) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = (i_sts.cls.c0 || i_sts.cls.del) ? KIND_CONTROL : KIND_PRINT;
                end
            end
            ST_ESCAPE: begin
                if (w_take) begin
                    if (i_sts.cls.csi_open) begin
                        o_cmd.csi_start = 1'b1;
                    end else if (!i_sts.cls.osc_open && !i_sts.cls.dcs_open
                                 && !i_sts.cls.sos_open) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_ESC_FINAL;
                    end
                end
            end
            ST_CSI_ENTRY, ST_CSI_PARAM, ST_CSI_INTER: begin
                if (w_take) begin
                    if (r_state != ST_CSI_INTER && i_sts.cls.param) begin
                        o_cmd.param_sep   = i_sts.cls.sep;
                        o_cmd.param_digit = !i_sts.cls.sep;
                    end else if (i_sts.cls.inter) begin
                        o_cmd.inter_collect = 1'b1;
                    end else if (i_sts.cls.fin) begin
                        o_cmd.kind = KIND_CSI_PARAM;
                        if (i_sts.used_zero) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = SRC_CSI_EMPTY;
                        end else if (i_sts.used_one) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = SRC_CSI_ACC;
                        end else begin
                            o_cmd.drain_start = 1'b1;
                        end
                    end else if (!i_sts.cls.esc && i_sts.cls.c0) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_CONTROL;
                    end
                end
            end
            ST_OSC: begin
                if (w_take && !i_sts.cls.esc) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = i_sts.cls.str_end ? KIND_OSC_END : KIND_OSC_BYTE;
                end
            end
            ST_SOS: begin
                o_cmd.emit = 1'b0;
            end
            ST_DCS_ENTRY, ST_DCS_PARAM, ST_DCS_INTER, ST_DCS_PASS: begin
                if (w_take) begin
                    if ((r_state == ST_DCS_ENTRY || r_state == ST_DCS_PARAM)
                        && i_sts.cls.param) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_DCS_BYTE;
                    end else if (r_state != ST_DCS_PASS && i_sts.cls.inter) begin
                        o_cmd.inter_collect = 1'b1;
                    end else if (i_sts.cls.str_end) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_DCS_END;
                    end else if (!i_sts.cls.esc) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = i_sts.cls.c0 ? KIND_CONTROL : KIND_DCS_BYTE;
                    end
                end
            end
            ST_DRAIN_RD: begin
                o_cmd.in_ready = 1'b0;
            end
            ST_DRAIN_OUT: begin
                o_cmd.in_ready = 1'b0;
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.kind       = KIND_CSI_PARAM;
                    o_cmd.src        = SRC_DRAIN_MEM;
                    o_cmd.drain_step = 1'b1;
                end
            end
            ST_DRAIN_LAST: begin
                o_cmd.in_ready = 1'b0;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_CSI_PARAM;
                    o_cmd.src  = SRC_DRAIN_ACC;
                end
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

    `TESP_ASSERT_IMPL(a_emit_needs_slot, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free,
        "result issued while the output register is still full")
    `TESP_ASSERT_IMPL(a_drain_has_params, i_clk, i_rst_n,
        r_state == ST_DRAIN_OUT || r_state == ST_DRAIN_RD,
        !i_sts.used_zero && !i_sts.used_one, "drain running with fewer than two params")
    `TESP_ASSERT_NEXT(a_drain_start_seq, i_clk, i_rst_n, o_cmd.drain_start,
        r_state == ST_DRAIN_RD, "drain start did not enter the read step")

endmodule

// ===== rtl/tesp_datapath.sv =====
// parameter accumulator, parameter memory, intermediate store and output register
`include "terminal_escape_sequence_parser_assert.svh"

module tesp_datapath
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS        = 16,
    parameter int MAX_INTERMEDIATES = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [BYTE_W-1:0]     i_in_byte,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic [KIND_W-1:0]     o_out_kind,
    output logic                  o_out_last
);

    localparam int UW          = $clog2(MAX_PARAMS + 1);
    localparam int IW          = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int IUW         = $clog2(MAX_INTERMEDIATES + 1);
    localparam int INTER_DEPTH = (MAX_INTERMEDIATES < 2) ? 2 : MAX_INTERMEDIATES;
    localparam int IIW         = $clog2(INTER_DEPTH);
    localparam int PROD_W      = VALUE_W + 4;
    localparam int PAD_W       = OUT_DATA_W - 2 * BYTE_W - INDEX_W - COUNT_W - VALUE_W
                                 - ICOUNT_W - BYTE_W;

    logic [VALUE_W-1:0] r_mem [MAX_PARAMS];
    logic [VALUE_W-1:0] r_rd_data;
    logic [VALUE_W-1:0] r_acc;
    logic [UW-1:0]      r_used;
    logic               r_drop;
    logic [UW-1:0]      r_k;
    logic [BYTE_W-1:0]  r_final;
    logic [BYTE_W-1:0]  r_inter [INTER_DEPTH];
    logic [IUW-1:0]     r_iused;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [KIND_W-1:0]     r_out_kind;
    logic                  r_out_last;

    logic               w_used_zero;
    logic [UW-1:0]      w_used_m1;
    logic [UW-1:0]      w_eff;
    logic [UW-1:0]      w_eff_m1;
    logic               w_room;
    logic [VALUE_W-1:0] w_commit;
    logic [VALUE_W-1:0] w_base;
    logic [PROD_W-1:0]  w_prod;
    logic [VALUE_W-1:0] w_sat;
    logic               w_out_free;

    logic [BYTE_W-1:0]   w_byte;
    logic [INDEX_W-1:0]  w_idx;
    logic [COUNT_W-1:0]  w_cnt;
    logic [VALUE_W-1:0]  w_val;
    logic [ICOUNT_W-1:0] w_icnt;
    logic [BYTE_W-1:0]   w_i1;
    logic [BYTE_W-1:0]   w_i2;
    logic                w_last;

    assign w_used_zero = (r_used == '0);
    assign w_used_m1   = r_used - UW'(1);
    // a separator on an empty list first opens parameter zero
    assign w_eff       = w_used_zero ? UW'(1) : r_used;
    assign w_eff_m1    = w_eff - UW'(1);
    assign w_room      = (w_eff < UW'(MAX_PARAMS));
    assign w_commit    = w_used_zero ? '0 : r_acc;
    assign w_base      = w_used_zero ? '0 : r_acc;

    // value * 10 + digit, digit is the low nibble of 0x30..0x3F
    assign w_prod = {1'b0, w_base, 3'b000} + {3'b000, w_base, 1'b0}
                  + {{(PROD_W - 4){1'b0}}, i_in_byte[3:0]};
    assign w_sat  = (w_prod[PROD_W-1:VALUE_W] != '0) ? {VALUE_W{1'b1}} : w_prod[VALUE_W-1:0];

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.cls             = classify(i_in_byte);
        o_sts.out_free        = w_out_free;
        o_sts.used_zero       = w_used_zero;
        o_sts.used_one        = (r_used == UW'(1));
        o_sts.drain_next_last = ({1'b0, r_k} + (UW + 1)'(2)) == {1'b0, r_used};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_drop  <= 1'b0;
            r_iused <= '0;
        end else begin
            if (i_cmd.csi_start) begin
                r_used  <= '0;
                r_drop  <= 1'b0;
                r_iused <= '0;
            end else begin
                if (i_cmd.param_sep) begin
                    if (w_room) begin
                        r_used <= w_eff + UW'(1);
                    end else begin
                        r_used <= w_eff;
                        r_drop <= 1'b1;
                    end
                end else if (i_cmd.param_digit && w_used_zero) begin
                    r_used <= UW'(1);
                end
                if (i_cmd.inter_collect && (r_iused < IUW'(MAX_INTERMEDIATES))) begin
                    r_iused <= r_iused + IUW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.param_sep) begin
            if (w_room) begin
                r_mem[w_eff_m1[IW-1:0]] <= w_commit;
                r_acc <= '0;
            end else begin
                r_acc <= w_commit;
            end
        end else if (i_cmd.param_digit && (w_used_zero || !r_drop)) begin
            r_acc <= w_sat;
        end
        r_rd_data <= r_mem[r_k[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.inter_collect && (r_iused < IUW'(MAX_INTERMEDIATES))) begin
            r_inter[r_iused[IIW-1:0]] <= i_in_byte;
        end
        if (i_cmd.drain_start) begin
            r_final <= i_in_byte;
            r_k     <= '0;
        end else if (i_cmd.drain_step) begin
            r_k <= r_k + UW'(1);
        end
    end

    // result record assembly
    always_comb begin
        w_byte = i_in_byte;
        w_idx  = '0;
        w_cnt  = '0;
        w_val  = '0;
        w_icnt = '0;
        w_i1   = '0;
        w_i2   = '0;
        w_last = 1'b1;
        if (i_cmd.src != SRC_BYTE) begin
            w_icnt = ICOUNT_W'(r_iused);
            w_i1   = (32'(r_iused) >= 32'd1) ? r_inter[0] : '0;
            w_i2   = (32'(r_iused) >= 32'd2) ? r_inter[1] : '0;
        end
        case (i_cmd.src)
            SRC_BYTE, SRC_CSI_EMPTY: begin
                w_last = 1'b1;
            end
            SRC_CSI_ACC: begin
                w_idx = INDEX_W'(w_used_m1);
                w_cnt = COUNT_W'(r_used);
                w_val = r_acc;
            end
            SRC_DRAIN_MEM: begin
                w_byte = r_final;
                w_idx  = INDEX_W'(r_k);
                w_cnt  = COUNT_W'(r_used);
                w_val  = r_rd_data;
                w_last = 1'b0;
            end
            SRC_DRAIN_ACC: begin
                w_byte = r_final;
                w_idx  = INDEX_W'(w_used_m1);
                w_cnt  = COUNT_W'(r_used);
                w_val  = r_acc;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.kind;
            r_out_last <= w_last;
            r_out_data <= {{PAD_W{1'b0}}, w_i2, w_i1, w_icnt, w_val, w_cnt, w_idx, w_byte};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

    `TESP_ASSERT_IMPL(a_drop_only_when_full, i_clk, i_rst_n, r_drop,
        r_used == UW'(MAX_PARAMS), "parameter drop set before the list is full")
    `TESP_ASSERT_ALWAYS(a_inter_bound, i_clk, i_rst_n,
        r_iused <= IUW'(MAX_INTERMEDIATES), "intermediate count past its limit")
    `TESP_ASSERT_NEXT(a_csi_clears, i_clk, i_rst_n, i_cmd.csi_start,
        r_used == '0 && r_iused == '0 && !r_drop, "csi entry left stale collection state")

endmodule

// ===== rtl/terminal_escape_sequence_parser.sv =====
// top level of the vt500 style terminal escape sequence parser
// Usage:
//   s_axis carries one received terminal byte per transfer in tdata[7:0].
//   m_axis carries event records: tuser[2:0] is the event kind, tlast marks
//   the final record caused by one input byte.
//   A byte that causes one event or none is taken without holding off the input; its record
//   appears on m_axis in the cycle after the transfer, from an output register.
//   s_axis_tready stays high while that register is empty or being drained,
//   so ordinary bytes stream at one per cycle.
//   A CSI final byte with n >= 2 parameters drains n records: each of the
//   first n-1 comes from the parameter memory through a registered read
//   (ST_DRAIN_RD, then ST_DRAIN_OUT), the last from the accumulator, and
//   the input is held off until the last record has been issued.
//   When m_axis_tready is low the output register holds its record and
//   s_axis_tready drops; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) returns the parser to ground mode and
//   empties the output register; stored parameters need no clearing.
module terminal_escape_sequence_parser
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS        = 16,
    parameter int MAX_INTERMEDIATES = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] in_byte
    input  logic [7:0]            s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] byte_value, [11:8] param_index, [16:12] param_count,
    // [32:17] param_value, [34:33] inter_count, [42:35] inter_first,
    // [50:43] inter_second, [55:51] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] event_kind
    output logic [KIND_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    tesp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tesp_datapath #(
        .MAX_PARAMS        (MAX_PARAMS),
        .MAX_INTERMEDIATES (MAX_INTERMEDIATES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    assign s_axis_tready = w_cmd.in_ready;

endmodule
